/* src/atr_pkg.sv */
package atr_pkg;

    // Longest rollout in poses.
    localparam int MAX_STEPS = 64;

    // Angles inside the block are Q.16 radians in 20 bits.
    localparam int ANG_W = 20;
    localparam logic signed [20:0] PI_Q16      = 21'sd205887;
    localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;
    localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
    localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
    localparam int CORDIC_N = 16;
    localparam logic signed [15:0] HEADING_MAX = 16'sd25736;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_INV_WHEELBASE    = 3'd0,
        REG_TIME_STEP        = 3'd1,
        REG_STEP_COUNT       = 3'd2,
        REG_INV_MAX_STEERING = 3'd3,
        REG_INV_MAX_SPEED    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [15:0] lin_speed;
        logic signed [15:0] steer_angle;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic signed [31:0] turn_rate;
        logic [5:0]         step_index;
        logic               last_pose;
        logic [15:0]        cost;
    } pose_t;

    // One classified sample waiting for the rollout engine.
    typedef struct packed {
        logic signed [15:0] speed;
        logic signed [31:0] turn_rate;
        logic signed [18:0] turn;
        logic [15:0]        cost;
        logic [6:0]         steps;
    } job_t;

    typedef struct packed {
        logic [23:0] inv_wheelbase;
        logic [15:0] time_step;
        logic [6:0]  step_count;
        logic [23:0] inv_max_steering;
        logic [23:0] inv_max_speed;
    } cfg_t;

    // Arctangent table of the rotation steps, Q.16 radians.
    function automatic logic signed [20:0] atan_q16(input logic [3:0] i);
        logic signed [20:0] r;
        begin
            case (i)
                4'd0:    r = 21'sd51472;
                4'd1:    r = 21'sd30386;
                4'd2:    r = 21'sd16055;
                4'd3:    r = 21'sd8150;
                4'd4:    r = 21'sd4091;
                4'd5:    r = 21'sd2047;
                4'd6:    r = 21'sd1024;
                4'd7:    r = 21'sd512;
                4'd8:    r = 21'sd256;
                4'd9:    r = 21'sd128;
                4'd10:   r = 21'sd64;
                4'd11:   r = 21'sd32;
                4'd12:   r = 21'sd16;
                4'd13:   r = 21'sd8;
                4'd14:   r = 21'sd4;
                default: r = 21'sd2;
            endcase
            return r;
        end
    endfunction

endpackage

/* src/atr_cordic.sv */
module atr_cordic
    import atr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ANG_W-1:0] angle,
    output logic                    done,
    output logic signed [17:0]      sin_q,
    output logic signed [17:0]      cos_q
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [3:0]         iter_reg, iter_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [20:0] z_reg, z_next;
    logic               neg_reg, neg_next;
    logic signed [20:0] a21;
    logic signed [33:0] shx, shy;
    logic signed [33:0] xr, yr;

    // Fold the angle into the convergence range, then rotate one step a cycle.
    always_comb
    begin
        a21       = 21'(angle);
        shx       = x_reg >>> iter_reg;
        shy       = y_reg >>> iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = 4'd0;
            x_next    = CORDIC_K;
            y_next    = 34'sd0;
            if (a21 > HALF_PI_Q16)
            begin
                z_next   = a21 - PI_Q16;
                neg_next = 1'b1;
            end
            else if (a21 < -HALF_PI_Q16)
            begin
                z_next   = a21 + PI_Q16;
                neg_next = 1'b1;
            end
            else
            begin
                z_next   = a21;
                neg_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (!z_reg[20])
            begin
                x_next = x_reg - shy;
                y_next = y_reg + shx;
                z_next = z_reg - atan_q16(iter_reg);
            end
            else
            begin
                x_next = x_reg + shy;
                y_next = y_reg - shx;
                z_next = z_reg + atan_q16(iter_reg);
            end
            iter_next = iter_reg + 4'd1;
            if (iter_reg == 4'(CORDIC_N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
    end

    // Round from Q.30 to Q.16 and undo the fold.
    always_comb
    begin
        xr    = (x_reg + 34'sd8192) >>> 14;
        yr    = (y_reg + 34'sd8192) >>> 14;
        cos_q = neg_reg ? -xr[17:0] : xr[17:0];
        sin_q = neg_reg ? -yr[17:0] : yr[17:0];
    end

    assign done = done_reg;

endmodule

/* src/atr_front.sv */
module atr_front
    import atr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample,
    output logic    job_push,
    output job_t    job,
    input  logic    job_full
);

    typedef enum logic [3:0] {
        F_IDLE, F_CORD, F_MUL1, F_MUL2, F_DIV_LOAD, F_DIV, F_ROUND, F_TURN, F_PUSH
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic signed [15:0] v_reg, d_reg;
    logic signed [17:0] sd_reg, cd_reg;
    logic signed [33:0] p1_reg;
    logic [40:0]        c1_reg;
    logic signed [39:0] c2_reg;
    logic signed [57:0] num_reg;
    logic [53:0]        t1_reg;
    logic signed [55:0] t2_reg;
    logic [57:0]        dvd_reg;
    logic [16:0]        dmag_reg;
    logic [17:0]        rem_reg;
    logic [5:0]         cnt_reg;
    logic               neg_reg;
    logic signed [31:0] tr_reg;
    logic [15:0]        cost_reg;
    logic signed [48:0] tt_reg;
    logic               accept;
    logic               cd_start, cd_done;
    logic signed [17:0] cd_sin, cd_cos;
    logic signed [16:0] ds, ad;
    logic signed [40:0] base;
    logic [17:0]        rs;
    logic signed [57:0] csum;
    logic signed [57:0] cr;
    logic signed [58:0] qs;
    logic signed [58:0] tf;
    logic signed [48:0] tq;
    logic [6:0]         steps;

    assign accept       = sample_valid && (state_reg == F_IDLE);
    assign sample_stall = (state_reg != F_IDLE);
    assign cd_start     = accept;

    atr_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cd_start),
        .angle (ANG_W'($signed({sample.steer_angle, 2'b00}))),
        .done  (cd_done),
        .sin_q (cd_sin),
        .cos_q (cd_cos)
    );

    // Operand preparation for the product and cost terms.
    always_comb
    begin
        ds   = 17'(d_reg);
        ad   = ds[16] ? -ds : ds;
        base = 41'sd268435456 - 41'(c2_reg);
        rs   = {rem_reg[16:0], dvd_reg[57]};
        csum = $signed({4'b0000, t1_reg}) + 58'(t2_reg);
        cr   = (csum + 58'sd536870912) >>> 30;
        qs   = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
        tf   = (qs + 59'sd2048) >>> 12;
        tq   = (tt_reg + 49'sd32768) >>> 16;
        if (cfg.step_count == 7'd0)
            steps = 7'd1;
        else if (cfg.step_count > 7'(MAX_STEPS))
            steps = 7'(MAX_STEPS);
        else
            steps = cfg.step_count;
    end

    // Sequencer state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:     if (accept) state_next = F_CORD;
            F_CORD:     if (cd_done) state_next = F_MUL1;
            F_MUL1:     state_next = F_MUL2;
            F_MUL2:     state_next = F_DIV_LOAD;
            F_DIV_LOAD: state_next = (cd_reg == 18'sd0) ? F_ROUND : F_DIV;
            F_DIV:      if (cnt_reg == 6'd57) state_next = F_ROUND;
            F_ROUND:    state_next = F_TURN;
            F_TURN:     state_next = F_PUSH;
            F_PUSH:     if (!job_full) state_next = F_IDLE;
            default:    state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    v_reg <= sample.lin_speed;
                    d_reg <= sample.steer_angle;
                end
            end
            F_CORD:
            begin
                if (cd_done)
                begin
                    sd_reg <= cd_sin;
                    cd_reg <= cd_cos;
                end
            end
            F_MUL1:
            begin
                p1_reg <= 34'(v_reg) * 34'(sd_reg);
                c1_reg <= 41'(ad) * 41'(cfg.inv_max_steering);
                c2_reg <= 40'(v_reg) * 40'($signed({1'b0, cfg.inv_max_speed}));
            end
            F_MUL2:
            begin
                num_reg <= 58'(p1_reg) * 58'($signed({1'b0, cfg.inv_wheelbase}));
                t1_reg  <= 54'(c1_reg) * 54'd6554;
                t2_reg  <= 56'(base) * 56'sd13108;
            end
            F_DIV_LOAD:
            begin
                dvd_reg  <= num_reg[57] ? 58'(-num_reg) : 58'(num_reg);
                dmag_reg <= cd_reg[17] ? 17'(-cd_reg) : 17'(cd_reg);
                rem_reg  <= 18'd0;
                cnt_reg  <= 6'd0;
                neg_reg  <= num_reg[57] ^ cd_reg[17];
            end
            F_DIV:
            begin
                // One quotient bit a cycle, restoring form.
                if (rs >= {1'b0, dmag_reg})
                begin
                    rem_reg <= rs - {1'b0, dmag_reg};
                    dvd_reg <= {dvd_reg[56:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rs;
                    dvd_reg <= {dvd_reg[56:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            F_ROUND:
            begin
                if (cd_reg == 18'sd0)
                begin
                    if (num_reg > 58'sd0)
                        tr_reg <= 32'sh7fffffff;
                    else if (num_reg < 58'sd0)
                        tr_reg <= 32'sh80000000;
                    else
                        tr_reg <= 32'sd0;
                end
                else if (tf > 59'sd2147483647)
                    tr_reg <= 32'sh7fffffff;
                else if (tf < -59'sd2147483648)
                    tr_reg <= 32'sh80000000;
                else
                    tr_reg <= tf[31:0];
                if (cr < 58'sd0)
                    cost_reg <= 16'd0;
                else if (cr > 58'sd65535)
                    cost_reg <= 16'hffff;
                else
                    cost_reg <= cr[15:0];
            end
            F_TURN:
            begin
                tt_reg <= 49'(tr_reg) * 49'($signed({1'b0, cfg.time_step}));
            end
            default:
            begin
            end
        endcase
    end

    // Classified word toward the rollout engine.
    always_comb
    begin
        job.speed     = v_reg;
        job.turn_rate = tr_reg;
        job.cost      = cost_reg;
        job.steps     = steps;
        if (tq > 49'(PI_Q16))
            job.turn = 19'(PI_Q16);
        else if (tq < -49'(PI_Q16))
            job.turn = 19'(-PI_Q16);
        else
            job.turn = tq[18:0];
    end

    assign job_push = (state_reg == F_PUSH) && !job_full;

endmodule

/* src/atr_fifo.sv */
module atr_fifo
    import atr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t pop_data,
    output logic empty
);

    job_t       mem [2];
    logic       wr_reg, rd_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem[rd_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

endmodule

/* src/atr_back.sv */
module atr_back
    import atr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic [15:0] time_step,
    input  logic  job_empty,
    input  job_t  job,
    output logic  job_pop,
    output logic  pose_valid,
    input  logic  pose_stall,
    output pose_t pose
);

    typedef enum logic [2:0] {
        B_IDLE, B_START, B_CORD, B_MUL1, B_MUL2, B_UPD, B_EMIT
    } bstate_t;

    bstate_t            state_reg, state_next;
    job_t               job_reg;
    logic signed [31:0] x_reg, y_reg;
    logic signed [15:0] h_reg;
    logic [6:0]         k_reg;
    logic signed [17:0] sm_reg, cm_reg;
    logic signed [33:0] px_reg, py_reg;
    logic signed [50:0] qx_reg, qy_reg;
    logic               pose_valid_reg;
    pose_t              pose_reg;
    logic               cd_start, cd_done;
    logic signed [17:0] cd_sin, cd_cos;
    logic signed [19:0] hx8, mid;
    logic signed [50:0] dx, dy;
    logic signed [33:0] sx, sy;
    logic signed [20:0] t, tw, hr;
    logic               last;
    logic               slot_free;

    assign job_pop   = (state_reg == B_IDLE) && !job_empty;
    assign cd_start  = (state_reg == B_START);
    assign last      = (k_reg == job_reg.steps - 7'd1);
    assign slot_free = !pose_valid_reg || !pose_stall;

    // Mid-step heading and the position and heading updates.
    always_comb
    begin
        hx8 = 20'($signed({h_reg, 3'b000}));
        mid = hx8 + 20'(job_reg.turn >>> 1);
        dx  = (qx_reg + 51'sd134217728) >>> 28;
        dy  = (qy_reg + 51'sd134217728) >>> 28;
        sx  = 34'(x_reg) + 34'(dx);
        sy  = 34'(y_reg) + 34'(dy);
        t   = 21'(hx8) + 21'(job_reg.turn);
        if (t > PI_Q16)
            tw = t - TWO_PI_Q16;
        else if (t < -PI_Q16)
            tw = t + TWO_PI_Q16;
        else
            tw = t;
        hr = (tw + 21'sd4) >>> 3;
    end

    atr_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cd_start),
        .angle (mid),
        .done  (cd_done),
        .sin_q (cd_sin),
        .cos_q (cd_cos)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (!job_empty) state_next = B_START;
            B_START: state_next = B_CORD;
            B_CORD:  if (cd_done) state_next = B_MUL1;
            B_MUL1:  state_next = B_MUL2;
            B_MUL2:  state_next = B_UPD;
            B_UPD:   state_next = B_EMIT;
            B_EMIT:  if (slot_free) state_next = last ? B_IDLE : B_START;
            default: state_next = B_IDLE;
        endcase
    end

    // State and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            pose_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_EMIT && slot_free)
                pose_valid_reg <= 1'b1;
            else if (!pose_stall)
                pose_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    job_reg <= job;
                    x_reg   <= 32'sd0;
                    y_reg   <= 32'sd0;
                    h_reg   <= 16'sd0;
                    k_reg   <= 7'd0;
                end
            end
            B_CORD:
            begin
                if (cd_done)
                begin
                    sm_reg <= cd_sin;
                    cm_reg <= cd_cos;
                end
            end
            B_MUL1:
            begin
                px_reg <= 34'(job_reg.speed) * 34'(cm_reg);
                py_reg <= 34'(job_reg.speed) * 34'(sm_reg);
            end
            B_MUL2:
            begin
                qx_reg <= 51'(px_reg) * 51'($signed({1'b0, time_step}));
                qy_reg <= 51'(py_reg) * 51'($signed({1'b0, time_step}));
            end
            B_UPD:
            begin
                if (sx > 34'sd2147483647)
                    x_reg <= 32'sh7fffffff;
                else if (sx < -34'sd2147483648)
                    x_reg <= 32'sh80000000;
                else
                    x_reg <= sx[31:0];
                if (sy > 34'sd2147483647)
                    y_reg <= 32'sh7fffffff;
                else if (sy < -34'sd2147483648)
                    y_reg <= 32'sh80000000;
                else
                    y_reg <= sy[31:0];
                if (hr > 21'(HEADING_MAX))
                    h_reg <= HEADING_MAX;
                else if (hr < -21'(HEADING_MAX))
                    h_reg <= -HEADING_MAX;
                else
                    h_reg <= hr[15:0];
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    pose_reg.pos_x      <= x_reg;
                    pose_reg.pos_y      <= y_reg;
                    pose_reg.heading    <= h_reg;
                    pose_reg.turn_rate  <= job_reg.turn_rate;
                    pose_reg.step_index <= k_reg[5:0];
                    pose_reg.last_pose  <= last;
                    pose_reg.cost       <= last ? job_reg.cost : 16'd0;
                    k_reg               <= k_reg + 7'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign pose_valid = pose_valid_reg;
    assign pose       = pose_reg;

endmodule

/* src/ackermann_trajectory_rollout.sv */
// Kinematic bicycle rollout: each accepted sample (speed, steering) produces
// step_count poses (clamped to 1..64), rolled out from the origin by midpoint
// integration, the last one flagged and carrying the sample cost. A front
// sequencer works out the yaw rate through a CORDIC sine/cosine and a
// bit-serial divider (skipped when the cosine is zero), and stays stalled
// meanwhile and while the queue is full. A two-word queue hands the result
// to the rollout engine, which works out each pose through its own CORDIC
// and can be held by a stalled pose output. Configuration writes must be
// made while the block is idle.
module ackermann_trajectory_rollout
    import atr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  sample_t     sample,
    output logic        pose_valid,
    input  logic        pose_stall,
    output pose_t       pose,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    cfg_t cfg_reg;
    logic job_push, job_full, job_pop, job_empty;
    job_t job_in, job_out;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_wheelbase    <= 24'd145636;
            cfg_reg.time_step        <= 16'd6554;
            cfg_reg.step_count       <= 7'd10;
            cfg_reg.inv_max_steering <= 24'd150314;
            cfg_reg.inv_max_speed    <= 24'd54613;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INV_WHEELBASE:    cfg_reg.inv_wheelbase    <= cfg_data;
                REG_TIME_STEP:        cfg_reg.time_step        <= cfg_data[15:0];
                REG_STEP_COUNT:       cfg_reg.step_count       <= cfg_data[6:0];
                REG_INV_MAX_STEERING: cfg_reg.inv_max_steering <= cfg_data;
                REG_INV_MAX_SPEED:    cfg_reg.inv_max_speed    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    atr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .job_push     (job_push),
        .job          (job_in),
        .job_full     (job_full)
    );

    atr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (job_out),
        .empty     (job_empty)
    );

    atr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .time_step  (cfg_reg.time_step),
        .job_empty  (job_empty),
        .job        (job_out),
        .job_pop    (job_pop),
        .pose_valid (pose_valid),
        .pose_stall (pose_stall),
        .pose       (pose)
    );

endmodule

/* tb/ackermann_trajectory_rollout_test.sv */
`timescale 1ns / 1ps

module ackermann_trajectory_rollout_test
    import atr_pkg::*;
;

    localparam longint CYCLE_LIMIT = 10000000;
    localparam longint PI_Q = 205887;
    localparam longint TWO_PI_Q = 411775;
    localparam longint HALF_PI_Q = 102944;
    localparam longint I32_MAX = 2147483647;
    localparam longint I32_MIN = -64'sd2147483648;
    localparam int STEER_LIM = 24576;
    localparam logic signed [15:0] STEER_FULL = 16'sd24576;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    sample_t     sample;
    logic        pose_valid;
    logic        pose_stall;
    pose_t       pose;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    // Local copy of the register file.
    logic [23:0] m_inv_wheelbase;
    logic [15:0] m_time_step;
    logic [6:0]  m_step_count;
    logic [23:0] m_inv_max_steering;
    logic [23:0] m_inv_max_speed;

    pose_t  pending_poses[$];
    int     error_count;
    int     mismatch_count;
    longint cycle_count;
    bit     quiet_sender;
    bit     quiet_receiver;

    ackermann_trajectory_rollout u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .pose_valid   (pose_valid),
        .pose_stall   (pose_stall),
        .pose         (pose),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // Round half up at bit s, then floor.
    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Rotation-mode CORDIC sine and cosine of a Q.16 angle, results in Q.16.
    function automatic void cordic_sincos(input longint ang, output longint s,
                                          output longint c);
        longint atan_steps[16];
        longint x, y, z, nx;
        bit flip;
        atan_steps = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                       256, 128, 64, 32, 16, 8, 4, 2};
        flip = 0;
        x = 652032874;
        y = 0;
        if (ang > HALF_PI_Q)
        begin
            ang -= PI_Q;
            flip = 1;
        end
        else if (ang < -HALF_PI_Q)
        begin
            ang += PI_Q;
            flip = 1;
        end
        z = ang;
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_steps[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_steps[i];
            end
            x = nx;
        end
        x = round_shift(x, 14);
        y = round_shift(y, 14);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Work out every pose of one rollout and queue it.
    function automatic void predict_rollout(sample_t smp);
        longint spd, str, ts, sd, cd, num, rate, turn, cost_v, abs_str, t1, t2;
        longint px, py, hd, h8, sm, cm, t;
        int n;
        pose_t p;
        spd = smp.lin_speed;
        str = smp.steer_angle;
        ts = m_time_step;
        cordic_sincos(str * 4, sd, cd);
        num = spd * sd * longint'(m_inv_wheelbase);
        if (cd == 0)
            rate = num > 0 ? I32_MAX : (num < 0 ? I32_MIN : 0);
        else
            rate = clamp(round_shift(num / cd, 12), I32_MIN, I32_MAX);
        turn = clamp(round_shift(rate * ts, 16), -PI_Q, PI_Q);
        abs_str = str < 0 ? -str : str;
        t1 = abs_str * longint'(m_inv_max_steering) * 6554;
        t2 = ((longint'(1) <<< 28) - spd * longint'(m_inv_max_speed)) * 3277 * 4;
        cost_v = clamp(round_shift(t1 + t2, 30), 0, 65535);
        n = m_step_count;
        if (n < 1)
            n = 1;
        if (n > MAX_STEPS)
            n = MAX_STEPS;
        px = 0;
        py = 0;
        hd = 0;
        for (int k = 0; k < n; k++)
        begin
            h8 = hd * 8;
            cordic_sincos(h8 + (turn >>> 1), sm, cm);
            px = clamp(px + round_shift(spd * cm * ts, 28), I32_MIN, I32_MAX);
            py = clamp(py + round_shift(spd * sm * ts, 28), I32_MIN, I32_MAX);
            t = h8 + turn;
            if (t > PI_Q)
                t -= TWO_PI_Q;
            else if (t < -PI_Q)
                t += TWO_PI_Q;
            hd = clamp(round_shift(t, 3), -25736, 25736);
            p.pos_x = px[31:0];
            p.pos_y = py[31:0];
            p.heading = hd[15:0];
            p.turn_rate = rate[31:0];
            p.step_index = k[5:0];
            p.last_pose = (k == n - 1);
            p.cost = (k == n - 1) ? cost_v[15:0] : 16'd0;
            pending_poses.insert(pending_poses.size(), p);
        end
    endfunction

    function automatic int gap_length();
        if ($urandom_range(0, 11) == 0)
            return $urandom_range(15, 70);
        return $urandom_range(0, 3);
    endfunction

    // Write one register; only called while the block is idle.
    task automatic write_reg(cfg_reg_t idx, logic [23:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_INV_WHEELBASE:    m_inv_wheelbase = value;
            REG_TIME_STEP:        m_time_step = value[15:0];
            REG_STEP_COUNT:       m_step_count = value[6:0];
            REG_INV_MAX_STEERING: m_inv_max_steering = value;
            REG_INV_MAX_SPEED:    m_inv_max_speed = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(logic [23:0] wb, logic [23:0] ts, logic [23:0] steps,
                             logic [23:0] ms, logic [23:0] mv);
        write_reg(REG_INV_WHEELBASE, wb);
        write_reg(REG_TIME_STEP, ts);
        write_reg(REG_STEP_COUNT, steps);
        write_reg(REG_INV_MAX_STEERING, ms);
        write_reg(REG_INV_MAX_SPEED, mv);
    endtask

    // Offer one word and hold it until accepted, then maybe idle.
    task automatic send_sample(logic signed [15:0] spd, logic signed [15:0] str);
        int gap;
        sample_valid <= 1'b1;
        sample.lin_speed <= spd;
        sample.steer_angle <= str;
        do
            @(posedge clk);
        while (sample_stall);
        predict_rollout('{lin_speed: spd, steer_angle: str});
        gap = quiet_sender ? 0 : gap_length();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(int max_abs_speed);
        logic signed [15:0] spd;
        logic signed [15:0] str;
        case ($urandom_range(0, 7))
            0: spd = 16'($urandom);
            1: spd = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            default: spd = 16'($urandom_range(0, 2 * max_abs_speed) - max_abs_speed);
        endcase
        if ($urandom_range(0, 9) == 0)
            str = ($urandom_range(0, 1) != 0) ? STEER_FULL : -STEER_FULL;
        else
            str = 16'($urandom_range(0, 2 * STEER_LIM) - STEER_LIM);
        send_sample(spd, str);
    endtask

    // Let every pose come out, then give the engine time to settle.
    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (pending_poses.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic test_field_extremes();
        write_all(145636, 6554, 10, 150314, 54613);
        send_sample(16'sh7fff, 16'sd0);
        send_sample(-16'sd32768, 16'sd0);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd4096, STEER_FULL);
        send_sample(16'sd4096, -STEER_FULL);
        send_sample(16'sh7fff, STEER_FULL);
        send_sample(-16'sd32768, -STEER_FULL);
        send_sample(-16'sd8192, 16'sd8000);
        send_sample(16'sd1, -16'sd1);
        wait_idle();
    endtask

    task automatic test_step_count_limits();
        // Zero steps still gives one pose; too many are capped.
        write_reg(REG_STEP_COUNT, 0);
        send_sample(16'sd12000, 16'sd5000);
        send_sample(-16'sd3000, -16'sd20000);
        wait_idle();
        write_reg(REG_STEP_COUNT, 127);
        send_sample(16'sh7fff, 16'sd20000);
        wait_idle();
        write_reg(REG_STEP_COUNT, 64);
        send_sample(16'sd20000, -STEER_FULL);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        // Zero reciprocals and zero step keep poses at the origin.
        write_all(0, 0, 3, 0, 0);
        send_sample(16'sh7fff, STEER_FULL);
        send_sample(-16'sd32768, -STEER_FULL);
        wait_idle();
        // Full-scale registers drive saturation of rate, turn, and cost.
        write_all(24'hffffff, 16'hffff, 4, 24'hffffff, 24'hffffff);
        send_sample(16'sh7fff, STEER_FULL);
        send_sample(-16'sd32768, -STEER_FULL);
        send_sample(16'sh7fff, 16'sd0);
        send_sample(-16'sd32768, 16'sd100);
        wait_idle();
        write_all(1, 1, 1, 1, 1);
        send_sample(16'sh7fff, STEER_FULL);
        send_sample(-16'sd32768, -16'sd7);
        wait_idle();
    endtask

    task automatic random_phase(int items, int max_steps, int max_abs_speed);
        write_all(24'($urandom_range(1, 24'hffffff) >> $urandom_range(0, 8)),
                  24'($urandom_range(1, 65535)),
                  24'($urandom_range(1, max_steps)),
                  24'($urandom_range(1, 24'hffffff) >> $urandom_range(0, 8)),
                  24'($urandom_range(1, 24'hffffff) >> $urandom_range(0, 8)));
        repeat (items) send_random(max_abs_speed);
        wait_idle();
    endtask

    task automatic test_random_mix();
        write_all(145636, 6554, 6, 150314, 54613);
        repeat (50) send_random(16384);
        wait_idle();
        quiet_sender = 1;
        quiet_receiver = 1;
        random_phase(40, 4, 32767);
        quiet_sender = 0;
        quiet_receiver = 0;
        random_phase(60, 8, 8192);
        random_phase(60, 3, 32767);
        random_phase(50, 6, 2048);
        random_phase(25, 16, 16384);
        random_phase(3, 64, 32767);
    endtask

    // Receiver stall: runs of stall or no stall, with quiet stretches.
    initial
    begin
        forever
        begin
            if (quiet_receiver)
                pose_stall <= 1'b0;
            else
                pose_stall <= ($urandom_range(0, 2) == 0);
            repeat (gap_length() + 1) @(posedge clk);
        end
    end

    // Compare each accepted pose with the oldest expectation.
    always @(posedge clk)
    begin
        pose_t want;
        if (rst_n && pose_valid && !pose_stall)
        begin
            if (pending_poses.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected pose word: %p", pose);
            end
            else
            begin
                want = pending_poses.pop_front();
                if (pose.pos_x !== want.pos_x || pose.pos_y !== want.pos_y
                    || pose.heading !== want.heading || pose.turn_rate !== want.turn_rate
                    || pose.step_index !== want.step_index
                    || pose.last_pose !== want.last_pose || pose.cost !== want.cost)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("pose mismatch: expected %p actual %p", want, pose);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        clk = 0;
        cycle_count = 0;
        error_count = 0;
        mismatch_count = 0;
        quiet_sender = 0;
        quiet_receiver = 0;
        rst_n <= 1'b0;
        sample_valid <= 1'b0;
        sample <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_INV_WHEELBASE;
        cfg_data <= '0;
        m_inv_wheelbase = 145636;
        m_time_step = 6554;
        m_step_count = 10;
        m_inv_max_steering = 150314;
        m_inv_max_speed = 54613;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_step_count_limits();
        test_register_extremes();
        test_random_mix();

        wait_idle();
        error_count += pending_poses.size();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
